/* design/tsr_pkg.sv */
package tsr_pkg;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] ack;
    logic [15:0] len;
    logic [15:0] tag;
    logic        ackf;
    logic        finf;
  } req_t;

endpackage

/* design/tsr_ram.sv */
module tsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/tsr_front.sv */
module tsr_front (
  input  logic          start,
  input  logic          q_full,
  input  tsr_pkg::req_t req,
  output logic          busy,
  output logic          q_push,
  output tsr_pkg::req_t q_data
);

  always_comb begin
    busy = q_full;
    q_push = start && !q_full && (req.len != 16'd0);
    q_data = req;
  end

endmodule

/* design/tsr_back.sv */
module tsr_back #(
  parameter int CACHE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  tsr_pkg::req_t q_data,
  output logic          q_pop,
  output logic          strobe,
  output logic [15:0]   out_tag,
  output logic [31:0]   out_seq,
  output logic [15:0]   out_length,
  output logic          result_kind,
  output logic          last_of_run,
  output logic          idle
);

  localparam int AW = $clog2(CACHE_DEPTH);
  localparam int CW = $clog2(CACHE_DEPTH + 1);
  localparam int EW = 64;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0]    state;
  logic          stream_open;
  logic [31:0]   rel_seq;
  logic [31:0]   last_ack;
  logic [15:0]   last_len;
  logic [CW-1:0] held_count;
  logic [CW-1:0] rd_idx;
  logic [CW-1:0] kept;
  logic [CW-1:0] walk_end;

  logic          pend;
  logic [EW-1:0] pend_data;
  logic          pend_kind;

  logic [32:0]   expect_sum;
  logic          we;
  logic [AW-1:0] waddr;
  logic [EW-1:0] wdata;
  logic [EW-1:0] rdata;
  logic [31:0]   r_seq;
  logic [15:0]   r_len;
  logic          r_match;

  assign expect_sum = {1'b0, rel_seq} + {17'd0, last_len};
  assign r_seq = rdata[63:32];
  assign r_len = rdata[31:16];
  assign r_match = ({1'b0, r_seq} == expect_sum);
  assign idle = (state == S_IDLE) && !pend;
  assign q_pop = q_valid && (state == S_IDLE);

  tsr_ram #(.WIDTH(EW), .DEPTH(CACHE_DEPTH)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(rd_idx[AW-1:0]), .rdata(rdata)
  );

  always_comb begin
    we = 1'b0;
    waddr = kept[AW-1:0];
    wdata = rdata;
    if (q_pop) begin
      waddr = held_count[AW-1:0];
      wdata = {q_data.seq, q_data.len, q_data.tag};
      we = stream_open && q_data.ackf && (q_data.ack == last_ack)
        && (q_data.seq != rel_seq) && ({1'b0, q_data.seq} > expect_sum)
        && (held_count < CW'(CACHE_DEPTH));
    end else if (state == S_WALK && !r_match) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= (q_pop && !stream_open)
        || ((state == S_READ) && (rd_idx == walk_end) && pend)
        || ((state == S_WALK) && r_match && pend);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      stream_open <= 1'b0;
      rel_seq <= '0;
      last_ack <= '0;
      last_len <= '0;
      held_count <= '0;
      rd_idx <= '0;
      kept <= '0;
      walk_end <= '0;
      pend <= 1'b0;
      last_of_run <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            rd_idx <= '0;
            kept <= '0;
            if (!stream_open) begin
              stream_open <= 1'b1;
              rel_seq <= q_data.seq;
              last_ack <= q_data.ack;
              last_len <= q_data.len;
              held_count <= '0;
              last_of_run <= 1'b1;
              out_tag <= q_data.tag;
              out_seq <= q_data.seq;
              out_length <= q_data.len;
              result_kind <= 1'b0;
            end else if (!q_data.ackf) begin
              if (q_data.finf) begin
                stream_open <= 1'b0;
                rel_seq <= '0;
                last_ack <= '0;
                last_len <= '0;
                held_count <= '0;
              end
            end else if ((q_data.ack == last_ack) && (q_data.seq != rel_seq)
                && ({1'b0, q_data.seq} >= expect_sum)) begin
              pend_data <= {q_data.seq, q_data.len, q_data.tag};
              if ({1'b0, q_data.seq} > expect_sum) begin
                pend_kind <= 1'b1;
                if (held_count < CW'(CACHE_DEPTH)) begin
                  held_count <= held_count + CW'(1);
                  walk_end <= held_count + CW'(1);
                  pend <= 1'b0;
                end else begin
                  walk_end <= held_count;
                  pend <= 1'b1;
                end
              end else begin
                walk_end <= held_count;
                pend <= 1'b1;
                pend_kind <= 1'b0;
                rel_seq <= q_data.seq;
                last_len <= q_data.len;
              end
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          if (rd_idx == walk_end) begin
            if (pend) begin
              last_of_run <= 1'b1;
              {out_seq, out_length, out_tag} <= pend_data;
              result_kind <= pend_kind;
              pend <= 1'b0;
            end
            held_count <= kept;
            state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + CW'(1);
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (r_match) begin
            if (pend) begin
              last_of_run <= 1'b0;
              {out_seq, out_length, out_tag} <= pend_data;
              result_kind <= pend_kind;
            end
            pend <= 1'b1;
            pend_kind <= 1'b0;
            pend_data <= rdata;
            rel_seq <= r_seq;
            last_len <= r_len;
          end else begin
            kept <= kept + CW'(1);
          end
          state <= S_READ;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count: assert property (@(posedge clk) disable iff (rst)
    held_count <= CW'(CACHE_DEPTH)) else $error("cache count overflow");
  a_kept: assert property (@(posedge clk) disable iff (rst)
    kept <= rd_idx) else $error("kept passes read index");
  a_idle_strobe: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> !(strobe && last_of_run)) else $error("early last");
`endif

endmodule

/* design/tcp_segment_reorder.sv */
// A stream-opening request waits in the one-entry input queue; the back end then registers
// its result and the strobe. A request that walks cached entries gives its last result at its end.
// Requests are served one at a time: a new one waits in the input queue, with busy high,
// while the walk visits each cached entry through the states S_READ and S_WALK in turn.
// Reset (rst, synchronous) closes the stream and empties the cache.
// Results are strobed for one cycle; the receiver cannot stall.
module tcp_segment_reorder #(
  parameter int CACHE_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] seq_number,
  input  logic [31:0] ack_number,
  input  logic [15:0] payload_length,
  input  logic [15:0] segment_tag,
  input  logic        ack_flag,
  input  logic        fin_flag,
  output logic        strobe,
  output logic [15:0] out_tag,
  output logic [31:0] out_seq,
  output logic [15:0] out_length,
  output logic        result_kind,
  output logic        last_of_run
);

  tsr_pkg::req_t req;
  tsr_pkg::req_t q_in;
  tsr_pkg::req_t q_data;
  logic          q_push;
  logic          q_valid;
  logic          q_pop;
  logic          idle;

  assign req = '{seq: seq_number, ack: ack_number, len: payload_length,
                 tag: segment_tag, ackf: ack_flag, finf: fin_flag};

  tsr_front u_front (
    .start(start), .q_full(q_valid), .req(req),
    .busy(busy), .q_push(q_push), .q_data(q_in)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_push) begin
      q_valid <= 1'b1;
    end else if (q_pop) begin
      q_valid <= 1'b0;
    end
    if (q_push) begin
      q_data <= q_in;
    end
  end

  tsr_back #(.CACHE_DEPTH(CACHE_DEPTH)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .strobe(strobe), .out_tag(out_tag), .out_seq(out_seq),
    .out_length(out_length), .result_kind(result_kind),
    .last_of_run(last_of_run), .idle(idle)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_valid) else $error("queue overrun");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    q_valid |-> busy) else $error("busy low with item queued");
  a_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> idle) else $error("pop while back busy");
`endif

endmodule

/* tb/tcp_segment_reorder_test.sv */
`timescale 1ns / 1ps

module tcp_segment_reorder_test;

  localparam int DEPTH = 32;
  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_DROP = 1'b1;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [15:0] tag;
    logic [31:0] seq;
    logic [15:0] len;
    logic        kind;
    logic        last;
  } segment_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] seq_number = '0;
  logic [31:0] ack_number = '0;
  logic [15:0] payload_length = '0;
  logic [15:0] segment_tag = '0;
  logic        ack_flag = 1'b0;
  logic        fin_flag = 1'b0;
  logic        strobe;
  logic [15:0] out_tag;
  logic [31:0] out_seq;
  logic [15:0] out_length;
  logic        result_kind;
  logic        last_of_run;

  segment_result_t pending_releases[$];
  int          errors = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;

  logic        open_q;
  logic [31:0] rel_seq_q, last_ack_q;
  logic [15:0] last_len_q;
  int          held_n;
  logic [31:0] held_seq_q[DEPTH];
  logic [15:0] held_len_q[DEPTH];
  logic [15:0] held_tag_q[DEPTH];

  tcp_segment_reorder #(.CACHE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .seq_number(seq_number), .ack_number(ack_number),
    .payload_length(payload_length), .segment_tag(segment_tag),
    .ack_flag(ack_flag), .fin_flag(fin_flag), .strobe(strobe),
    .out_tag(out_tag), .out_seq(out_seq), .out_length(out_length),
    .result_kind(result_kind), .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    segment_result_t exp_r;
    if (!rst && strobe) begin
      if (pending_releases.size() == 0) begin
        $error("unexpected result tag %h seq %h", out_tag, out_seq);
        errors++;
      end else begin
        exp_r = pending_releases.pop_front();
        if (out_tag !== exp_r.tag) begin
          $error("out_tag exp %h got %h", exp_r.tag, out_tag); errors++;
        end
        if (out_seq !== exp_r.seq) begin
          $error("out_seq exp %h got %h", exp_r.seq, out_seq); errors++;
        end
        if (out_length !== exp_r.len) begin
          $error("out_length exp %h got %h", exp_r.len, out_length); errors++;
        end
        if (result_kind !== exp_r.kind) begin
          $error("result_kind exp %b got %b", exp_r.kind, result_kind); errors++;
        end
        if (last_of_run !== exp_r.last) begin
          $error("last_of_run exp %b got %b", exp_r.last, last_of_run); errors++;
        end
      end
    end
  end

  function automatic void push_result(logic [15:0] tag, logic [31:0] seq,
                                      logic [15:0] len, logic kind);
    segment_result_t r;
    r.tag = tag; r.seq = seq; r.len = len; r.kind = kind; r.last = 1'b0;
    pending_releases.push_back(r);
  endfunction

  function automatic logic [32:0] len_ext(logic [15:0] l);
    return {17'b0, l};
  endfunction

  function automatic void predict_reorder(logic [31:0] seq, logic [31:0] ack,
                                          logic [15:0] len, logic [15:0] tag,
                                          logic ackf, logic finf);
    logic [32:0] next_seq;
    int base, kept;
    base = pending_releases.size();
    if (len == 0) return;
    if (!open_q) begin
      open_q = 1'b1; rel_seq_q = seq; last_ack_q = ack; last_len_q = len;
      held_n = 0;
      push_result(tag, seq, len, KIND_RELEASE);
      pending_releases[base].last = 1'b1;
      return;
    end
    if (!ackf) begin
      if (finf) begin
        open_q = 1'b0; rel_seq_q = '0; last_ack_q = '0; last_len_q = '0;
        held_n = 0;
      end
      return;
    end
    if (ack != last_ack_q || seq == rel_seq_q) return;
    next_seq = {1'b0, rel_seq_q} + len_ext(last_len_q);
    if (next_seq > {1'b0, seq}) return;
    if (next_seq < {1'b0, seq}) begin
      if (held_n < DEPTH) begin
        held_seq_q[held_n] = seq; held_len_q[held_n] = len;
        held_tag_q[held_n] = tag; held_n++;
      end else begin
        push_result(tag, seq, len, KIND_DROP);
      end
    end else begin
      push_result(tag, seq, len, KIND_RELEASE);
      rel_seq_q = seq; last_ack_q = ack; last_len_q = len;
      next_seq = {1'b0, seq} + len_ext(len);
    end
    kept = 0;
    for (int i = 0; i < held_n; i++) begin
      if ({1'b0, held_seq_q[i]} == next_seq) begin
        push_result(held_tag_q[i], held_seq_q[i], held_len_q[i], KIND_RELEASE);
        rel_seq_q = held_seq_q[i]; last_len_q = held_len_q[i];
        next_seq = {1'b0, held_seq_q[i]} + len_ext(held_len_q[i]);
      end else begin
        held_seq_q[kept] = held_seq_q[i]; held_len_q[kept] = held_len_q[i];
        held_tag_q[kept] = held_tag_q[i]; kept++;
      end
    end
    held_n = kept;
    if (pending_releases.size() > base)
      pending_releases[pending_releases.size() - 1].last = 1'b1;
  endfunction

  task automatic send_segment(logic [31:0] seq, logic [31:0] ack, logic [15:0] len,
                              logic [15:0] tag, logic ackf, logic finf);
    while (!quiet && $urandom_range(99) < 11) begin
      start <= 1'b0;
      @(negedge clk);
    end
    seq_number <= seq; ack_number <= ack; payload_length <= len;
    segment_tag <= tag; ack_flag <= ackf; fin_flag <= finf;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_reorder(seq, ack, len, tag, ackf, finf);
    @(negedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending_releases.size() != 0) @(negedge clk);
    repeat (2 * DEPTH + 8) @(negedge clk);
  endtask

  task automatic test_directed;
    send_segment(32'h0, 32'h0, 16'h0, 16'h1, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h0100, 16'hFFFF, 1'b0, 1'b1);
    send_segment(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h0010, 16'h2, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h0010, 16'h3, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF10, 32'h0, 16'h0010, 16'h4, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF30, 32'hFFFF_FFFF, 16'h0010, 16'h5, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF20, 32'hFFFF_FFFF, 16'h0010, 16'h6, 1'b1, 1'b1);
    send_segment(32'hFFFF_FF08, 32'hFFFF_FFFF, 16'h0010, 16'h7, 1'b1, 1'b0);
    send_segment(32'hFFFF_FF40, 32'hFFFF_FFFF, 16'hFFFF, 16'h8, 1'b1, 1'b0);
    send_segment(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 16'h9, 1'b0, 1'b0);
    send_segment(32'h0, 32'h0, 16'h1, 16'hA, 1'b0, 1'b1);
    send_segment(32'h0, 32'h0, 16'h1, 16'hB, 1'b1, 1'b1);
    send_segment(32'h0, 32'h0, 16'h1, 16'hC, 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_cache_full;
    logic [31:0] base;
    base = 32'h1000;
    if (open_q)
      send_segment(32'hAAAA_5555, 32'h5555_AAAA, 16'h1, 16'h10, 1'b0, 1'b1);
    send_segment(base, 32'h5555_AAAA, 16'h10, 16'h11, 1'b0, 1'b0);
    for (int i = DEPTH + 1; i >= 0; i--)
      send_segment(base + 32'(16 * (i + 1)), 32'h5555_AAAA, 16'h10,
                   16'(32'h100 + i), 1'b1, 1'b0);
    drain();
  endtask

  task automatic test_random_streams;
    logic [31:0] base, ack;
    int n, order[$];
    for (int s = 0; s < 26; s++) begin
      quiet = (s >= 8 && s < 12);
      base = $urandom; ack = $urandom;
      n = $urandom_range(12, 2);
      if (open_q)
        send_segment(32'h0, 32'h0, 16'h1, 16'h0, 1'b0, 1'b1);
      send_segment(base, ack, 16'($urandom_range(64, 1)), 16'($urandom), 1'b1, 1'b0);
      order.delete();
      for (int i = 0; i < n; i++) order.push_back(i);
      order.shuffle();
      foreach (order[i]) begin
        case ($urandom_range(9))
          0: send_segment($urandom, $urandom, 16'($urandom), 16'($urandom),
                          1'($urandom), 1'b0);
          1: send_segment(open_q ? rel_seq_q : base, ack, 16'($urandom_range(8, 1)),
                          16'($urandom), 1'b1, 1'($urandom));
          default: send_segment(rel_seq_q + 32'(last_len_q) + 32'(order[i] * 8),
                                ack, 16'h8, 16'($urandom), 1'b1, 1'($urandom));
        endcase
      end
    end
    quiet = 1'b0;
    drain();
  endtask

  initial begin
    open_q = 1'b0; rel_seq_q = '0; last_ack_q = '0; last_len_q = '0; held_n = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_cache_full();
    test_random_streams();
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
